// ===== design/cfd_pkg.sv =====
// Shared constants, types and command codes for the command frame dispatcher.
// No dependencies; every other design file imports this package.
package cfd_pkg;

    localparam int NAME_CHARS    = 8;
    localparam int COMMAND_COUNT = 3;
    localparam int KEY_COUNT     = 3;
    localparam int NAME_W        = 64;
    localparam int LEN_W         = $clog2(NAME_CHARS + 2);
    localparam int CFG_IDX_W     = 2;

    localparam logic [7:0] CHAR_END   = 8'd0;
    localparam logic [7:0] CHAR_COMMA = 8'd44;
    localparam logic [7:0] CHAR_ZERO  = 8'd48;

    typedef logic [1:0] t_cmd;
    localparam t_cmd CMD_LED_ON  = 2'd0;
    localparam t_cmd CMD_LED_OFF = 2'd1;
    localparam t_cmd CMD_SERVO   = 2'd2;
    localparam t_cmd CMD_NONE    = 2'd3;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_KEY_LED_ON  = 2'd0;
    localparam t_cfg_idx CFG_KEY_LED_OFF = 2'd1;
    localparam t_cfg_idx CFG_KEY_SERVO   = 2'd2;

    // Keywords packed first character in the low byte: "ledon", "ledoff", "servo".
    localparam logic [NAME_W-1:0] KEY_RESET [KEY_COUNT] = '{
        64'd474315253100,
        64'd112590141547884,
        64'd478728578419
    };

    typedef struct packed {
        logic [NAME_W-1:0] name;
        logic              too_long;
        logic [7:0]        number;
    } t_frame;

endpackage

// ===== design/cfd_if.sv =====
// Channel interfaces of the command frame dispatcher: bytes in, results out,
// keyword register writes. Depends on cfd_pkg.
interface cfd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;

    modport source (output valid, output byte_value, input ready);
    modport sink   (input valid, input byte_value, output ready);
endinterface

interface cfd_result_if;
    import cfd_pkg::*;
    logic       valid;
    logic       ready;
    t_cmd       command_found;
    logic [7:0] argument_value;
    logic [7:0] port_bits;

    modport source (output valid, output command_found, output argument_value,
                    output port_bits, input ready);
    modport sink   (input valid, input command_found, input argument_value,
                    input port_bits, output ready);
endinterface

interface cfd_cfg_if;
    import cfd_pkg::*;
    logic              valid;
    logic              ready;
    t_cfg_idx          reg_index;
    logic [NAME_W-1:0] wr_data;

    modport source (output valid, output reg_index, output wr_data, input ready);
    modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

// ===== design/command_frame_dispatcher_top.sv =====
// Top level of the command frame dispatcher: input register, frame state,
// keyword match, port image and result register. Depends on cfd_pkg, cfd_if, cfd_frame.
//
// Use: characters of a "name,number" frame enter on i_byte, one per item; a
// zero byte ends the frame and yields exactly one item on o_result with the
// matched command (3 when nothing matched), the parsed number and the port
// image after led on / led off was applied. Other bytes yield nothing.
// Keyword registers are written over i_cfg, which is always ready; write them
// only while no frame end is in flight.
// Flow: a byte is held in the input register and processed from there; a
// result appears in the result register after its zero byte has left the
// input register. Throughput is one byte per cycle, save that a zero byte
// waits while a result is pending and stalled, as below.
// When o_result stalls, non-terminating bytes keep flowing; only a second
// zero byte waits in the input register until the pending result is taken.
// Synchronous reset clears the frame, the port image, the keywords to their
// defaults and both valid flags.
module command_frame_dispatcher_top (
    input  logic  i_clk,
    input  logic  i_rst_n,
    cfd_byte_if.sink     i_byte,
    cfd_cfg_if.sink      i_cfg,
    cfd_result_if.source o_result
);
    import cfd_pkg::*;

    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_out_valid;
    t_cmd              r_out_cmd;
    logic [7:0]        r_out_arg;
    logic [7:0]        r_out_port;
    logic [7:0]        r_port, n_port;
    logic [NAME_W-1:0] r_key [KEY_COUNT];

    logic   advance;
    logic   is_end;
    logic   end_strobe;
    t_frame frame;
    t_cmd   cmd;

    assign is_end     = (r_in_byte == CHAR_END);
    assign advance    = !is_end || !r_out_valid || o_result.ready;
    assign end_strobe = r_in_valid && advance && is_end;
    assign i_byte.ready = !r_in_valid || advance;
    assign i_cfg.ready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_byte.ready) begin
            r_in_valid <= i_byte.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.ready) begin
            r_in_byte <= i_byte.byte_value;
        end
    end

    cfd_frame u_frame (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_valid && advance),
        .i_byte  (r_in_byte),
        .o_frame (frame)
    );

    // Descending scan so the lowest matching keyword wins.
    always_comb begin
        cmd = CMD_NONE;
        for (int k = COMMAND_COUNT - 1; k >= 0; k--) begin
            if (!frame.too_long && (r_key[k] == frame.name)) begin
                cmd = t_cmd'(k);
            end
        end
    end

    always_comb begin
        n_port = r_port;
        if (frame.number <= 8'd7) begin
            if (cmd == CMD_LED_ON) begin
                n_port = r_port | (8'd1 << frame.number[2:0]);
            end else if (cmd == CMD_LED_OFF) begin
                n_port = r_port & ~(8'd1 << frame.number[2:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_port      <= '0;
            r_out_valid <= 1'b0;
        end else if (end_strobe) begin
            r_port      <= n_port;
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (end_strobe) begin
            r_out_cmd  <= cmd;
            r_out_arg  <= frame.number;
            r_out_port <= n_port;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < KEY_COUNT; k++) begin
                r_key[k] <= KEY_RESET[k];
            end
        end else if (i_cfg.valid) begin
            case (i_cfg.reg_index)
                CFG_KEY_LED_ON:  r_key[0] <= i_cfg.wr_data;
                CFG_KEY_LED_OFF: r_key[1] <= i_cfg.wr_data;
                CFG_KEY_SERVO:   r_key[2] <= i_cfg.wr_data;
                default: begin
                end
            endcase
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.command_found  = r_out_cmd;
    assign o_result.argument_value = r_out_arg;
    assign o_result.port_bits      = r_out_port;

endmodule

// ===== design/cfd_frame.sv =====
// Frame state of the dispatcher: name collection, comma tracking and the
// decimal accumulator. Depends on cfd_pkg.
module cfd_frame (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [7:0]      i_byte,
    output cfd_pkg::t_frame o_frame
);
    import cfd_pkg::*;

    logic [1:0]        r_comma, n_comma;
    logic [NAME_W-1:0] r_name,  n_name;
    logic [LEN_W-1:0]  r_len,   n_len;
    logic [7:0]        r_num,   n_num;

    always_comb begin
        n_comma = r_comma;
        n_name  = r_name;
        n_len   = r_len;
        n_num   = r_num;
        if (i_valid) begin
            if (i_byte == CHAR_END) begin
                n_comma = '0;
                n_name  = '0;
                n_len   = '0;
                n_num   = '0;
            end else if (i_byte == CHAR_COMMA) begin
                if (r_comma < 2'd2) begin
                    n_comma = r_comma + 2'd1;
                end
            end else if (r_comma == 2'd0) begin
                if (r_len < LEN_W'(NAME_CHARS)) begin
                    // Lanes at and past the current length are still zero.
                    for (int i = 0; i < NAME_CHARS; i++) begin
                        if (r_len == LEN_W'(i)) begin
                            n_name[8*i +: 8] = i_byte;
                        end
                    end
                    n_len = r_len + LEN_W'(1);
                end else begin
                    n_len = LEN_W'(NAME_CHARS + 1);
                end
            end else if (r_comma == 2'd1) begin
                n_num = (r_num << 3) + (r_num << 1) + i_byte - CHAR_ZERO;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_comma <= '0;
            r_name  <= '0;
            r_len   <= '0;
            r_num   <= '0;
        end else begin
            r_comma <= n_comma;
            r_name  <= n_name;
            r_len   <= n_len;
            r_num   <= n_num;
        end
    end

    assign o_frame.name     = r_name;
    assign o_frame.too_long = (r_len > LEN_W'(NAME_CHARS));
    assign o_frame.number   = r_num;

endmodule

// ===== design/cfd_checker.sv =====
// Port-level checks for the command frame dispatcher and the bind that attaches
// them to command_frame_dispatcher_top. Depends on cfd_pkg.
module cfd_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_ready,
    input logic            i_res_valid,
    input logic            i_res_ready,
    input cfd_pkg::t_cmd   i_res_cmd,
    input logic [7:0]      i_res_arg,
    input logic [7:0]      i_res_port
);
    import cfd_pkg::*;

    // Port image carried by the last delivered result.
    logic [7:0] r_last_port;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_port <= '0;
        end else if (i_res_valid && i_res_ready) begin
            r_last_port <= i_res_port;
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("result dropped while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid right after reset");

    a_in_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_res_valid |-> i_in_ready)
        else $error("input blocked with empty result register");

    a_port_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && (i_res_cmd == CMD_SERVO || i_res_cmd == CMD_NONE
            || i_res_arg > 8'd7) |-> i_res_port == r_last_port)
        else $error("port image changed without a pin command");

    a_port_led: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_arg <= 8'd7 && i_res_cmd == CMD_LED_ON
            |-> i_res_port == (r_last_port | (8'd1 << i_res_arg[2:0])))
        else $error("led on did not set the pin");

endmodule

bind command_frame_dispatcher_top cfd_checker u_cfd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_byte.ready),
    .i_res_valid (o_result.valid),
    .i_res_ready (o_result.ready),
    .i_res_cmd   (o_result.command_found),
    .i_res_arg   (o_result.argument_value),
    .i_res_port  (o_result.port_bits)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for command_frame_dispatcher_top: text frames go in one byte per item,
// and each result is compared with a predicted command, argument and port image.
// Depends on cfd_pkg, the channel interfaces in cfd_if and the design under test.
module tb;
    import cfd_pkg::*;

    localparam t_cfg_idx CFG_IDX_UNUSED = 2'd3;
    localparam int       DRAIN_CYCLES   = 4;
    localparam int       STALL_LIMIT    = 2000;

    typedef struct {
        t_cmd       cmd;
        logic [7:0] arg;
        logic [7:0] port;
    } t_dispatch_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    cfd_byte_if   byte_ch ();
    cfd_cfg_if    cfg_ch ();
    cfd_result_if result_ch ();

    command_frame_dispatcher_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (byte_ch),
        .i_cfg    (cfg_ch),
        .o_result (result_ch)
    );

    always #5 i_clk = ~i_clk;

    // Predicted block state.
    logic [NAME_W-1:0] keyword_regs [KEY_COUNT];
    logic [1:0]        comma_cnt;
    logic [NAME_W-1:0] name_buf;
    logic [LEN_W-1:0]  name_len;
    logic [7:0]        num_acc;
    logic [7:0]        port_img;

    // Keywords as the stimulus generator knows them, set when they are written.
    logic [NAME_W-1:0] gen_keywords [KEY_COUNT];

    t_dispatch_result  expected_results [$];
    t_dispatch_result  head;
    logic [7:0]        pending_bytes [$];
    int                bytes_queued = 0;
    int                error_count  = 0;
    int                idle_cycles  = 0;
    int                gap_left;
    int                stall_left;
    bit                idling_on    = 1'b1;

    function automatic void predict_byte(input logic [7:0] b);
        t_dispatch_result r;
        if (b != CHAR_END) begin
            if (b == CHAR_COMMA) begin
                if (comma_cnt < 2) comma_cnt++;
            end else if (comma_cnt == 0) begin
                if (name_len < NAME_CHARS) begin
                    name_buf[8*name_len +: 8] = b;
                    name_len++;
                end else begin
                    name_len = LEN_W'(NAME_CHARS + 1);
                end
            end else if (comma_cnt == 1) begin
                num_acc = num_acc * 8'd10 + b - CHAR_ZERO;
            end
        end else begin
            // The first keyword that equals the name wins; an overlong name matches nothing.
            if (name_len > NAME_CHARS)
                r.cmd = CMD_NONE;
            else if (COMMAND_COUNT > 0 && keyword_regs[CFG_KEY_LED_ON] == name_buf)
                r.cmd = CMD_LED_ON;
            else if (COMMAND_COUNT > 1 && keyword_regs[CFG_KEY_LED_OFF] == name_buf)
                r.cmd = CMD_LED_OFF;
            else if (COMMAND_COUNT > 2 && keyword_regs[CFG_KEY_SERVO] == name_buf)
                r.cmd = CMD_SERVO;
            else
                r.cmd = CMD_NONE;
            r.arg = num_acc;
            if (num_acc <= 7) begin
                case (r.cmd)
                    CMD_LED_ON:  port_img[num_acc[2:0]] = 1'b1;
                    CMD_LED_OFF: port_img[num_acc[2:0]] = 1'b0;
                    default: ;
                endcase
            end
            r.port = port_img;
            expected_results.push_back(r);
            comma_cnt = '0;
            name_buf  = '0;
            name_len  = '0;
            num_acc   = '0;
        end
    endfunction

    // Byte driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            byte_ch.valid      <= 1'b0;
            byte_ch.byte_value <= '0;
            gap_left           <= 0;
        end else if (!byte_ch.valid || byte_ch.ready) begin
            if (gap_left > 0) begin
                gap_left      <= gap_left - 1;
                byte_ch.valid <= 1'b0;
            end else if (idling_on && pending_bytes.size() != 0
                         && $urandom_range(0, 6) == 0) begin
                gap_left      <= $urandom_range(0, 2);
                byte_ch.valid <= 1'b0;
            end else if (pending_bytes.size() != 0) begin
                byte_ch.valid      <= 1'b1;
                byte_ch.byte_value <= pending_bytes.pop_front();
            end else begin
                byte_ch.valid <= 1'b0;
            end
        end
    end

    // Result receiver with random stalls.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
            stall_left      <= 0;
        end else if (stall_left > 0) begin
            stall_left      <= stall_left - 1;
            result_ch.ready <= 1'b0;
        end else if (idling_on && $urandom_range(0, 4) == 0) begin
            stall_left      <= $urandom_range(0, 2);
            result_ch.ready <= 1'b0;
        end else begin
            result_ch.ready <= 1'b1;
        end
    end

    // Monitor: predicts on accepted bytes and writes, checks accepted results.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            idle_cycles++;
            if (cfg_ch.valid && cfg_ch.ready) begin
                idle_cycles = 0;
                if (cfg_ch.reg_index < KEY_COUNT)
                    keyword_regs[cfg_ch.reg_index] = cfg_ch.wr_data;
            end
            if (byte_ch.valid && byte_ch.ready) begin
                idle_cycles = 0;
                predict_byte(byte_ch.byte_value);
            end
            if (result_ch.valid && result_ch.ready) begin
                idle_cycles = 0;
                if (expected_results.size() == 0) begin
                    $display("%0t: result with none expected: cmd %0d arg %0d port %02h",
                             $time, result_ch.command_found, result_ch.argument_value,
                             result_ch.port_bits);
                    error_count++;
                end else begin
                    head = expected_results.pop_front();
                    if (result_ch.command_found !== head.cmd) begin
                        $display("%0t: command_found expected %0d actual %0d",
                                 $time, head.cmd, result_ch.command_found);
                        error_count++;
                    end
                    if (result_ch.argument_value !== head.arg) begin
                        $display("%0t: argument_value expected %0d actual %0d",
                                 $time, head.arg, result_ch.argument_value);
                        error_count++;
                    end
                    if (result_ch.port_bits !== head.port) begin
                        $display("%0t: port_bits expected %02h actual %02h",
                                 $time, head.port, result_ch.port_bits);
                        error_count++;
                    end
                end
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
                $display("** command_frame_dispatcher_top: FAILED **");
                $finish;
            end
        end
    end

    task automatic push_byte(input logic [7:0] b);
        pending_bytes.push_back(b);
        bytes_queued++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endtask

    // Pushes the name held in a keyword, up to its first zero byte.
    // Mode 1 disturbs the first character, mode 2 appends one.
    task automatic push_keyword(input logic [NAME_W-1:0] kw, input int mode);
        logic [7:0] c;
        for (int i = 0; i < NAME_CHARS; i++) begin
            c = kw[8*i +: 8];
            if (c == CHAR_END) break;
            if (mode == 1 && i == 0) c ^= 8'h01;
            push_byte(c);
        end
        if (mode == 2) push_byte("x");
    endtask

    function automatic logic [NAME_W-1:0] random_name(input int len);
        logic [NAME_W-1:0] n;
        n = '0;
        for (int i = 0; i < len; i++)
            n[8*i +: 8] = 8'($urandom_range(97, 122));
        return n;
    endfunction

    task automatic write_keyword(input t_cfg_idx idx, input logic [NAME_W-1:0] data);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.reg_index <= idx;
        cfg_ch.wr_data   <= data;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
    endtask

    task automatic load_keywords(input logic [NAME_W-1:0] k0, input logic [NAME_W-1:0] k1,
                                 input logic [NAME_W-1:0] k2, input bit try_unused);
        write_keyword(CFG_KEY_LED_ON, k0);
        write_keyword(CFG_KEY_LED_OFF, k1);
        write_keyword(CFG_KEY_SERVO, k2);
        if (try_unused)
            write_keyword(CFG_IDX_UNUSED, {$urandom, $urandom});
        cfg_ch.valid <= 1'b0;
        gen_keywords[CFG_KEY_LED_ON]  = k0;
        gen_keywords[CFG_KEY_LED_OFF] = k1;
        gen_keywords[CFG_KEY_SERVO]   = k2;
    endtask

    // Waits until every byte is taken and every result has come back.
    task automatic wait_drained();
        @(posedge i_clk);
        while (pending_bytes.size() != 0 || byte_ch.valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic add_random_frames(input int budget);
        int start;
        int kind;
        int k;
        int n;
        start = bytes_queued;
        while (bytes_queued - start < budget) begin
            kind = $urandom_range(0, 9);
            k    = $urandom_range(0, KEY_COUNT - 1);
            if (kind <= 5) begin
                // Well-formed command with a random number, sometimes trailing junk.
                push_keyword(gen_keywords[k], 0);
                push_byte(CHAR_COMMA);
                if ($urandom_range(0, 4) == 0) push_byte(CHAR_ZERO);
                if (k != CFG_KEY_SERVO && $urandom_range(0, 3) != 0)
                    n = $urandom_range(0, 7);
                else
                    n = $urandom_range(0, 255);
                if ($urandom_range(0, 9) == 0) n = $urandom_range(256, 9999);
                push_text($sformatf("%0d", n));
                if ($urandom_range(0, 5) == 0) begin
                    push_byte(CHAR_COMMA);
                    repeat ($urandom_range(0, 3)) push_byte(8'($urandom_range(1, 255)));
                end
            end else if (kind == 6) begin
                n = $urandom_range(1, NAME_CHARS);
                push_keyword(random_name(n), 0);
                push_byte(CHAR_COMMA);
                push_text($sformatf("%0d", $urandom_range(0, 9)));
            end else if (kind == 7) begin
                repeat ($urandom_range(NAME_CHARS + 1, NAME_CHARS + 4))
                    push_byte(8'($urandom_range(97, 122)));
                if ($urandom_range(0, 1) == 0) push_text(",5");
            end else if (kind == 8) begin
                repeat ($urandom_range(0, 10)) push_byte(8'($urandom_range(1, 255)));
            end else begin
                push_keyword(gen_keywords[k], $urandom_range(1, 2));
                push_text(",3");
            end
            push_byte(CHAR_END);
        end
    endtask

    initial begin
        logic [NAME_W-1:0] shared_name;
        i_rst_n            = 1'b0;
        byte_ch.valid      = 1'b0;
        byte_ch.byte_value = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.reg_index   = CFG_KEY_LED_ON;
        cfg_ch.wr_data     = '0;
        result_ch.ready    = 1'b0;
        for (int i = 0; i < KEY_COUNT; i++) begin
            keyword_regs[i] = KEY_RESET[i];
            gen_keywords[i] = KEY_RESET[i];
        end
        comma_cnt = '0;
        name_buf  = '0;
        name_len  = '0;
        num_acc   = '0;
        port_img  = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed frames on one-letter keywords; the servo keyword is empty.
        load_keywords(64'h6E, 64'h66, '0, 1'b1);
        push_text("n,7");
        push_byte(CHAR_END);
        push_text("f,0,9");
        push_byte(CHAR_END);
        push_text(",255");
        push_byte(CHAR_END);
        push_text("n,8");
        push_byte(CHAR_END);
        repeat (NAME_CHARS + 1) push_byte(8'hFF);
        push_byte(CHAR_END);
        push_text("q");
        push_byte(CHAR_END);
        wait_drained();

        load_keywords(KEY_RESET[0], KEY_RESET[1], KEY_RESET[2], 1'b0);
        add_random_frames(200);
        wait_drained();

        // Full-width keywords: all ones, eight letters, and arbitrary bits.
        load_keywords('1, random_name(NAME_CHARS), {$urandom, $urandom}, 1'b1);
        add_random_frames(150);
        wait_drained();

        // Two keywords equal: the lower command must win.
        shared_name = random_name($urandom_range(1, NAME_CHARS));
        load_keywords(shared_name, random_name($urandom_range(1, NAME_CHARS)), shared_name,
                      1'b0);
        add_random_frames(150);
        wait_drained();

        idling_on = 1'b0;
        load_keywords(KEY_RESET[0], KEY_RESET[1], KEY_RESET[2], 1'b0);
        add_random_frames(150);
        wait_drained();
        repeat (2 * DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0)
            $display("** command_frame_dispatcher_top: PASSED **");
        else
            $display("** command_frame_dispatcher_top: FAILED **");
        $finish;
    end

endmodule

// ===== files.f =====
design/cfd_pkg.sv
design/cfd_if.sv
design/cfd_frame.sv
design/command_frame_dispatcher_top.sv
design/cfd_checker.sv
tb/tb.sv
